/* rtl/ddodo_pkg.sv */
// ----------------------------------------------------------------------------
// ddodo_pkg
// Shared types, constants and functions for the differential drive odometry.
// ----------------------------------------------------------------------------
package ddodo_pkg;

    localparam int ITER_W = 5;

    localparam logic [1:0] REG_DIST_PER_COUNT  = 2'd0;
    localparam logic [1:0] REG_ANGLE_PER_DIFF  = 2'd1;
    localparam logic [1:0] REG_TICKS_PER_SEC   = 2'd2;

    localparam logic [31:0] DIST_PER_COUNT_RST = 32'd242098;
    localparam logic [31:0] ANGLE_PER_DIFF_RST = 32'd308250;
    localparam logic [9:0]  TICKS_PER_SEC_RST  = 10'd25;

    // CORDIC gain reciprocal, Q1.30
    localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;

    localparam logic signed [63:0] SAT40_MAX = 64'sd549755813887;
    localparam logic signed [63:0] SAT40_MIN = -64'sd549755813888;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_ANGLE,
        ST_ROT,
        ST_MAP,
        ST_MXL,
        ST_MXH,
        ST_MYL,
        ST_MYH,
        ST_SUM,
        ST_UPDATE,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PREP,
        OP_ANGLE,
        OP_ROT,
        OP_MAP,
        OP_MXL,
        OP_MXH,
        OP_MYL,
        OP_MYH,
        OP_SUM,
        OP_UPDATE
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [ITER_W-1:0]   iter;
        logic                out_load;
    } dp_cmd_t;

    // arctan(2^-i) in 2^-32 turn
    function automatic logic [31:0] cordic_atan(input logic [ITER_W-1:0] i);
        logic [31:0] a;
        case (i)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            5'd24:   a = 32'h00000029;
            5'd25:   a = 32'h00000014;
            5'd26:   a = 32'h0000000A;
            5'd27:   a = 32'h00000005;
            5'd28:   a = 32'h00000003;
            5'd29:   a = 32'h00000001;
            5'd30:   a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
        logic signed [39:0] r;
        if (v > SAT40_MAX) begin
            r = SAT40_MAX[39:0];
        end else if (v < SAT40_MIN) begin
            r = SAT40_MIN[39:0];
        end else begin
            r = v[39:0];
        end
        return r;
    endfunction

endpackage

/* rtl/ddodo_ctrl.sv */
// ----------------------------------------------------------------------------
// ddodo_ctrl
// Sequencer: steps the datapath through one odometry update per transfer.
// ----------------------------------------------------------------------------
module ddodo_ctrl
    import ddodo_pkg::*;
#(
    parameter int CORDIC_STAGES = 24
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output dp_cmd_t cmd
);

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STAGES - 1);

    ctrl_state_t       state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iter_reg    <= iter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:  state_next = ST_ANGLE;
            ST_ANGLE: begin
                state_next = ST_ROT;
                iter_next  = '0;
            end
            ST_ROT: begin
                if (iter_reg == ITER_LAST) begin
                    state_next = ST_MAP;
                end else begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_MAP:    state_next = ST_MXL;
            ST_MXL:    state_next = ST_MXH;
            ST_MXH:    state_next = ST_MYL;
            ST_MYL:    state_next = ST_MYH;
            ST_MYH:    state_next = ST_SUM;
            ST_SUM:    state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op       = OP_NONE;
        cmd.iter     = iter_reg;
        cmd.out_load = 1'b0;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = OP_LOAD;
                end
            end
            ST_PREP:   cmd.op = OP_PREP;
            ST_ANGLE:  cmd.op = OP_ANGLE;
            ST_ROT:    cmd.op = OP_ROT;
            ST_MAP:    cmd.op = OP_MAP;
            ST_MXL:    cmd.op = OP_MXL;
            ST_MXH:    cmd.op = OP_MXH;
            ST_MYL:    cmd.op = OP_MYL;
            ST_MYH:    cmd.op = OP_MYH;
            ST_SUM:    cmd.op = OP_SUM;
            ST_UPDATE: cmd.op = OP_UPDATE;
            ST_DONE:   cmd.out_load = !m_valid_reg || m_ready;
            default:   cmd.op = OP_NONE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* rtl/ddodo_dp.sv */
// ----------------------------------------------------------------------------
// ddodo_dp
// Datapath: travel/turn products, iterative CORDIC, pose accumulators and
// result register.
// ----------------------------------------------------------------------------
module ddodo_dp
    import ddodo_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    input  logic signed [15:0]  s_left_count,
    input  logic signed [15:0]  s_right_count,
    input  logic                s_clear_relative,
    input  logic [31:0]         dist_per_count,
    input  logic [31:0]         angle_per_diff,
    input  logic [9:0]          ticks_per_sec,
    output logic signed [39:0]  m_pos_x,
    output logic signed [39:0]  m_pos_y,
    output logic [31:0]         m_heading,
    output logic signed [39:0]  m_rel_travel,
    output logic signed [39:0]  m_rel_turn,
    output logic signed [39:0]  m_speed_est,
    output logic signed [39:0]  m_turn_rate_est
);

    // latched item
    logic signed [15:0] left_reg, right_reg;
    logic               clear_reg;

    // products and CORDIC
    logic signed [49:0] ds_prod_reg;
    logic signed [49:0] dth_reg;
    logic signed [40:0] ds_reg;
    logic [1:0]         quad_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic signed [31:0] c_reg, s_reg;
    logic signed [52:0] plo_reg, phi_reg;
    logic signed [43:0] dx_reg, dy_reg;
    logic signed [51:0] spd_prod_reg;
    logic signed [60:0] trt_prod_reg;

    // accumulators
    logic signed [39:0] x_acc_reg, y_acc_reg, travel_acc_reg, turn_acc_reg;
    logic [31:0]        heading_acc_reg;

    // result register
    logic signed [39:0] pos_x_reg, pos_y_reg, rel_travel_reg, rel_turn_reg;
    logic signed [39:0] speed_reg, turn_rate_reg;
    logic [31:0]        heading_reg;

    logic signed [16:0] cnt_sum, cnt_diff;
    logic signed [32:0] dpc_s, apc_s;
    logic signed [49:0] ds_rnd;
    logic [31:0]        mid, mid_q, ru;
    logic [1:0]         quad;
    logic signed [33:0] cx_sh, cy_sh, atan_s;
    logic signed [33:0] cx_next, cy_next, cz_next;
    logic signed [33:0] cx_neg, cy_neg;
    logic signed [31:0] c_next, s_next;
    logic signed [31:0] mul_op;
    logic signed [20:0] ds_lo, ds_hi;
    logic signed [52:0] mlo, mhi;
    logic signed [32:0] plo_sh;
    logic signed [53:0] dsum;
    logic signed [10:0] tps_s;
    logic signed [44:0] x_sum, y_sum;
    logic signed [41:0] trv_sum;
    logic signed [50:0] trn_sum;
    logic signed [39:0] trv_base, trn_base;

    assign cnt_sum  = 17'(left_reg) + 17'(right_reg);
    assign cnt_diff = 17'(left_reg) - 17'(right_reg);
    assign dpc_s    = $signed({1'b0, dist_per_count});
    assign apc_s    = $signed({1'b0, angle_per_diff});
    assign ds_rnd   = ds_prod_reg + 50'sd256;

    // mid-step heading, reduced to the nearest quarter turn
    assign mid   = heading_acc_reg + dth_reg[32:1];
    assign mid_q = mid + 32'h2000_0000;
    assign quad  = mid_q[31:30];
    assign ru    = mid - {quad, 30'd0};

    assign cx_sh  = cx_reg >>> cmd.iter;
    assign cy_sh  = cy_reg >>> cmd.iter;
    assign atan_s = $signed({2'b00, cordic_atan(cmd.iter)});

    always_comb begin
        if (!cz_reg[33]) begin
            cx_next = cx_reg - cy_sh;
            cy_next = cy_reg + cx_sh;
            cz_next = cz_reg - atan_s;
        end else begin
            cx_next = cx_reg + cy_sh;
            cy_next = cy_reg - cx_sh;
            cz_next = cz_reg + atan_s;
        end
    end

    assign cx_neg = -cx_reg;
    assign cy_neg = -cy_reg;

    always_comb begin
        case (quad_reg)
            2'd0: begin
                c_next = cx_reg[31:0];
                s_next = cy_reg[31:0];
            end
            2'd1: begin
                c_next = cy_neg[31:0];
                s_next = cx_reg[31:0];
            end
            2'd2: begin
                c_next = cx_neg[31:0];
                s_next = cy_neg[31:0];
            end
            default: begin
                c_next = cy_reg[31:0];
                s_next = cx_neg[31:0];
            end
        endcase
    end

    // ds * cos/sin split into a 20-bit low part and a signed high part
    assign mul_op = (cmd.op == OP_MYL || cmd.op == OP_MYH) ? s_reg : c_reg;
    assign ds_lo  = $signed({1'b0, ds_reg[19:0]});
    assign ds_hi  = ds_reg[40:20];
    assign mlo    = 53'(ds_lo) * 53'(mul_op);
    assign mhi    = 53'(ds_hi) * 53'(mul_op);
    assign plo_sh = plo_reg[52:20];
    assign dsum   = 54'(phi_reg) + 54'(plo_sh);

    assign tps_s = $signed({1'b0, ticks_per_sec});

    assign x_sum    = 45'(x_acc_reg) + 45'(dx_reg);
    assign y_sum    = 45'(y_acc_reg) + 45'(dy_reg);
    assign trv_base = clear_reg ? '0 : travel_acc_reg;
    assign trn_base = clear_reg ? '0 : turn_acc_reg;
    assign trv_sum  = 42'(trv_base) + 42'(ds_reg);
    assign trn_sum  = 51'(trn_base) + 51'(dth_reg);

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                left_reg  <= s_left_count;
                right_reg <= s_right_count;
                clear_reg <= s_clear_relative;
            end
            OP_PREP: begin
                ds_prod_reg <= 50'(cnt_sum) * 50'(dpc_s);
                dth_reg     <= 50'(cnt_diff) * 50'(apc_s);
            end
            OP_ANGLE: begin
                ds_reg   <= ds_rnd[49:9];
                quad_reg <= quad;
                cx_reg   <= CORDIC_INV_GAIN;
                cy_reg   <= '0;
                cz_reg   <= $signed({{2{ru[31]}}, ru});
            end
            OP_ROT: begin
                cx_reg <= cx_next;
                cy_reg <= cy_next;
                cz_reg <= cz_next;
            end
            OP_MAP: begin
                c_reg <= c_next;
                s_reg <= s_next;
            end
            OP_MXL:  plo_reg <= mlo + 53'sd536870912;
            OP_MXH:  phi_reg <= mhi;
            OP_MYL: begin
                dx_reg  <= dsum[53:10];
                plo_reg <= mlo + 53'sd536870912;
            end
            OP_MYH:  phi_reg <= mhi;
            OP_SUM: begin
                dy_reg       <= dsum[53:10];
                spd_prod_reg <= 52'(ds_reg) * 52'(tps_s);
                trt_prod_reg <= 61'(dth_reg) * 61'(tps_s);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_acc_reg       <= '0;
            y_acc_reg       <= '0;
            heading_acc_reg <= '0;
            travel_acc_reg  <= '0;
            turn_acc_reg    <= '0;
        end else if (cmd.op == OP_UPDATE) begin
            x_acc_reg       <= sat40(64'(x_sum));
            y_acc_reg       <= sat40(64'(y_sum));
            heading_acc_reg <= heading_acc_reg + dth_reg[31:0];
            travel_acc_reg  <= sat40(64'(trv_sum));
            turn_acc_reg    <= sat40(64'(trn_sum));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            pos_x_reg      <= x_acc_reg;
            pos_y_reg      <= y_acc_reg;
            heading_reg    <= heading_acc_reg;
            rel_travel_reg <= travel_acc_reg;
            rel_turn_reg   <= turn_acc_reg;
            speed_reg      <= sat40(64'(spd_prod_reg));
            turn_rate_reg  <= sat40(64'(trt_prod_reg));
        end
    end

    assign m_pos_x         = pos_x_reg;
    assign m_pos_y         = pos_y_reg;
    assign m_heading       = heading_reg;
    assign m_rel_travel    = rel_travel_reg;
    assign m_rel_turn      = rel_turn_reg;
    assign m_speed_est     = speed_reg;
    assign m_turn_rate_est = turn_rate_reg;

endmodule

/* rtl/differential_drive_odometry.sv */
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Dead-reckoning pose tracker for a two-wheel differential drive.
// ----------------------------------------------------------------------------
// Input channel (s_): one transfer per control tick carries the signed left
// and right encoder count changes and a flag that zeroes relative travel and
// turn before the update. Result channel (m_): one transfer per input with
// pose (Q16.24 m, binary-angle heading), relative travel and turn, and speed
// and turn rate estimates.
// After an input transfer the sequencer steps through PREP, ANGLE, the
// CORDIC_STAGES rotation steps, MAP, MXL, MXH, MYL, MYH, SUM, UPDATE and
// DONE, which loads the result register. The rotation is one CORDIC step
// per cycle and ds * cos/sin uses four split multiplies, so one item is
// in flight at a time. The result sits in an output register; a stalled
// receiver holds it while the next item is already computed, which then
// waits for the register. Configuration is an APB port (0x0 distance per
// count, 0x4 angle per count difference, 0x8 ticks per second); the user
// must write it only while the block is idle (not enforced by the block).
// Reset (aresetn low, synchronous) zeroes pose and relative sums and loads
// the register defaults.
// ----------------------------------------------------------------------------
module differential_drive_odometry
    import ddodo_pkg::*;
#(
    parameter int CORDIC_STAGES = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_left_count,
    input  logic signed [15:0]  s_right_count,
    input  logic                s_clear_relative,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [39:0]  m_pos_x,
    output logic signed [39:0]  m_pos_y,
    output logic [31:0]         m_heading,
    output logic signed [39:0]  m_rel_travel,
    output logic signed [39:0]  m_rel_turn,
    output logic signed [39:0]  m_speed_est,
    output logic signed [39:0]  m_turn_rate_est
);

    localparam logic [ITER_W-1:0] CORDIC_LAST = ITER_W'(CORDIC_STAGES - 1);

    logic [31:0] dist_per_count_reg;
    logic [31:0] angle_per_diff_reg;
    logic [9:0]  ticks_per_sec_reg;
    logic        cfg_wr;
    dp_cmd_t     dp_cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_per_count_reg <= DIST_PER_COUNT_RST;
            angle_per_diff_reg <= ANGLE_PER_DIFF_RST;
            ticks_per_sec_reg  <= TICKS_PER_SEC_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_DIST_PER_COUNT: dist_per_count_reg <= pwdata;
                REG_ANGLE_PER_DIFF: angle_per_diff_reg <= pwdata;
                REG_TICKS_PER_SEC:  ticks_per_sec_reg  <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DIST_PER_COUNT: prdata = dist_per_count_reg;
            REG_ANGLE_PER_DIFF: prdata = angle_per_diff_reg;
            REG_TICKS_PER_SEC:  prdata = {22'd0, ticks_per_sec_reg};
            default:            prdata = '0;
        endcase
    end

    ddodo_ctrl #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (dp_cmd)
    );

    ddodo_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (dp_cmd),
        .s_left_count     (s_left_count),
        .s_right_count    (s_right_count),
        .s_clear_relative (s_clear_relative),
        .dist_per_count   (dist_per_count_reg),
        .angle_per_diff   (angle_per_diff_reg),
        .ticks_per_sec    (ticks_per_sec_reg),
        .m_pos_x          (m_pos_x),
        .m_pos_y          (m_pos_y),
        .m_heading        (m_heading),
        .m_rel_travel     (m_rel_travel),
        .m_rel_turn       (m_rel_turn),
        .m_speed_est      (m_speed_est),
        .m_turn_rate_est  (m_turn_rate_est)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an update is in progress");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.out_load |-> (!m_valid || m_ready))
        else $error("result register overwritten before transfer");

    a_result_valid_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.out_load |=> m_valid)
        else $error("loaded result not presented");

    a_cordic_iter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.op == OP_ROT) |-> (dp_cmd.iter <= CORDIC_LAST))
        else $error("CORDIC step index past last stage");
`endif

endmodule
